/* design/lisc_pkg.sv */
// Package for the lyric id string code block: sequencer states, shared unit
// operations, control struct, multiplier constants and the id key function.
// No dependencies.
package lisc_pkg;

    localparam logic [31:0] FWD_MULT_EVEN = 32'd9;
    localparam logic [31:0] FWD_MULT_ODD  = 32'd17;
    localparam logic [31:0] WGT_MULT_EVEN = 32'd17;
    localparam logic [31:0] WGT_MULT_ODD  = 32'd33;

    localparam logic [31:0] ID_BYTE0_MASK = 32'h0000_00FF;
    localparam logic [31:0] ID_BYTE1_MASK = 32'h0000_FF00;
    localparam logic [31:0] ID_BYTE2_MASK = 32'h00FF_0000;
    localparam logic [31:0] ID_BYTE3_MASK = 32'hFF00_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FWD,
        ST_REV,
        ST_WGT,
        ST_MIX,
        ST_MUL1,
        ST_MUL2
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_FWD,
        OP_REV,
        OP_WGT,
        OP_MIX,
        OP_MUL1,
        OP_MUL2
    } op_t;

    // status into the sequencer
    typedef struct packed {
        logic in_valid;
        logic in_no_byte;
        logic in_last;
        logic item_last;
        logic out_busy;
    } seq_status_t;

    // control out of the sequencer
    typedef struct packed {
        logic in_ready;
        op_t  op;
        logic code_load;
    } seq_ctrl_t;

    // key from the song id: bytes rearranged, a zero id byte 2 or 3 replaced by the inverted id byte 1 or 0
    function automatic logic [31:0] make_key(input logic [31:0] id);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] k2;
        logic [7:0] k0;
        b0 = 8'((id & ID_BYTE0_MASK) >> 0);
        b1 = 8'((id & ID_BYTE1_MASK) >> 8);
        b2 = 8'((id & ID_BYTE2_MASK) >> 16);
        b3 = 8'((id & ID_BYTE3_MASK) >> 24);
        k2 = (b2 == 8'd0) ? ~b1 : b2;
        k0 = (b3 == 8'd0) ? ~b0 : b3;
        return {b0, k2, b1, k0};
    endfunction

endpackage

/* design/lisc_mac.sv */
// Shared multiply-add unit: res = a * b + c, modulo 2^32.
// Depends on nothing; destination registers sit in the top level.
module lisc_mac (
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    input  logic [31:0] op_c,
    output logic [31:0] res
);

    logic [31:0] prod;

    assign prod = op_a * op_b;
    assign res  = prod + op_c;

endmodule

/* design/lisc_seq.sv */
// Sequencer for the lyric id string code block: steps one transaction
// through the shared multiply-add unit. Depends on lisc_pkg.
module lisc_seq import lisc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  seq_status_t status,
    output seq_ctrl_t   ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (status.in_valid) begin
                    if (!status.in_no_byte) begin
                        state_next = ST_FWD;
                    end else if (status.in_last) begin
                        state_next = ST_MIX;
                    end
                end
            end
            ST_FWD:  state_next = ST_REV;
            ST_REV:  state_next = ST_WGT;
            ST_WGT:  state_next = status.item_last ? ST_MIX : ST_IDLE;
            ST_MIX:  state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: begin
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl.in_ready  = 1'b0;
        ctrl.op        = OP_NONE;
        ctrl.code_load = 1'b0;
        case (state_reg)
            ST_IDLE: ctrl.in_ready = 1'b1;
            ST_FWD:  ctrl.op = OP_FWD;
            ST_REV:  ctrl.op = OP_REV;
            ST_WGT:  ctrl.op = OP_WGT;
            ST_MIX:  ctrl.op = OP_MIX;
            ST_MUL1: ctrl.op = OP_MUL1;
            ST_MUL2: begin
                ctrl.op        = OP_MUL2;
                ctrl.code_load = !status.out_busy;
            end
            default: ctrl.op = OP_NONE;
        endcase
    end

endmodule

/* design/lyric_id_string_code_core.sv */
// Top level of the lyric id string code block: hash and weight registers,
// operand selection, output register. Depends on lisc_pkg, lisc_mac, lisc_seq.
//
//  channel | signals                                        | role
//  --------+------------------------------------------------+-----------------------
//  s_      | s_valid s_ready s_data_byte s_no_byte          | string byte in, last
//          | s_last_byte s_song_id                          | mark and song id
//  m_      | m_valid m_ready m_code                         | verification code out
//  cfg_    | cfg_valid cfg_ready cfg_byte_is_signed         | sign-extend setting
//
// A transaction carrying a byte is accepted, then runs the forward hash, reverse
// hash and weight update on the one shared multiply-add unit. An empty, non-last
// transaction is only accepted. A last transaction adds the code combine (mix,
// two multiplies), then the code sits in the output register.
// Reset (aresetn low, synchronous) clears hashes and parity, and sets the weight and
// the sign-extend setting to 1. A result not yet taken holds only the final multiply
// step; the input side stays ready while the code waits, until the next code reaches it.
module lyric_id_string_code_core import lisc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_no_byte,
    input  logic               s_last_byte,
    input  logic [31:0]        s_song_id,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_code,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_byte_is_signed
);

    seq_status_t status;
    seq_ctrl_t   ctrl;

    // architectural string state
    logic [31:0] fwd_hash_reg;
    logic [31:0] rev_hash_reg;
    logic [31:0] weight_reg;
    logic        parity_reg;
    logic        sign_reg;

    // per-transaction working registers
    logic [31:0] byte_val_reg;
    logic [31:0] song_id_reg;
    logic        last_reg;
    logic [31:0] acc_reg;

    // output register
    logic               m_valid_reg;
    logic signed [31:0] code_reg;

    logic [31:0] mac_a;
    logic [31:0] mac_b;
    logic [31:0] mac_c;
    logic [31:0] mac_res;
    logic [31:0] key;
    logic [31:0] byte_ext;
    logic        accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = ctrl.in_ready;
    assign accept    = s_valid && ctrl.in_ready;
    assign m_valid   = m_valid_reg;
    assign m_code    = code_reg;

    assign status.in_valid   = s_valid;
    assign status.in_no_byte = s_no_byte;
    assign status.in_last    = s_last_byte;
    assign status.item_last  = last_reg;
    assign status.out_busy   = m_valid_reg && !m_ready;

    assign key      = make_key(song_id_reg);
    assign byte_ext = {{24{sign_reg & s_data_byte[7]}}, s_data_byte};

    lisc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    // operand selection for the shared unit
    always_comb begin
        mac_a = 32'd0;
        mac_b = 32'd0;
        mac_c = 32'd0;
        case (ctrl.op)
            OP_FWD: begin
                mac_a = fwd_hash_reg;
                mac_b = parity_reg ? FWD_MULT_ODD : FWD_MULT_EVEN;
                mac_c = byte_val_reg;
            end
            OP_REV: begin
                mac_a = byte_val_reg;
                mac_b = weight_reg;
                mac_c = rev_hash_reg;
            end
            OP_WGT: begin
                mac_a = weight_reg;
                mac_b = parity_reg ? WGT_MULT_ODD : WGT_MULT_EVEN;
            end
            OP_MIX: begin
                // add as a multiply by one
                mac_a = rev_hash_reg ^ key;
                mac_b = 32'd1;
                mac_c = fwd_hash_reg | song_id_reg;
            end
            OP_MUL1: begin
                mac_a = acc_reg;
                mac_b = fwd_hash_reg | key;
            end
            OP_MUL2: begin
                mac_a = acc_reg;
                mac_b = rev_hash_reg ^ song_id_reg;
            end
            default: begin
                mac_a = 32'd0;
            end
        endcase
    end

    lisc_mac u_mac (
        .op_a (mac_a),
        .op_b (mac_b),
        .op_c (mac_c),
        .res  (mac_res)
    );

    // capture of the incoming transaction, the accumulator and the code register
    always_ff @(posedge aclk) begin
        if (accept) begin
            byte_val_reg <= byte_ext;
            song_id_reg  <= s_song_id;
            last_reg     <= s_last_byte;
        end
        if (ctrl.op == OP_MIX || ctrl.op == OP_MUL1) begin
            acc_reg <= mac_res;
        end
        if (ctrl.code_load) begin
            code_reg <= mac_res;
        end
    end

    // string state; back to its reset values once the code is formed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hash_reg <= 32'd0;
            rev_hash_reg <= 32'd0;
            weight_reg   <= 32'd1;
            parity_reg   <= 1'b0;
        end else if (ctrl.code_load) begin
            fwd_hash_reg <= 32'd0;
            rev_hash_reg <= 32'd0;
            weight_reg   <= 32'd1;
            parity_reg   <= 1'b0;
        end else begin
            if (ctrl.op == OP_FWD) begin
                fwd_hash_reg <= mac_res;
            end
            if (ctrl.op == OP_REV) begin
                rev_hash_reg <= mac_res;
            end
            if (ctrl.op == OP_WGT) begin
                weight_reg <= mac_res;
                parity_reg <= !parity_reg;
            end
        end
    end

    // settings and output handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sign_reg    <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                sign_reg <= cfg_byte_is_signed;
            end
            if (ctrl.code_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* bench/lisc_code_checker.sv */
// Code checker for lyric_id_string_code_core: watches the string, result and
// setting channels, predicts each verification code and compares it on arrival.
// Depends on lisc_pkg for the multiplier constants only.
module lisc_code_checker import lisc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_no_byte,
    input  logic               s_last_byte,
    input  logic [31:0]        s_song_id,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_code,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic               cfg_byte_is_signed,
    output int                 fail_count,
    output int                 codes_pending,
    output int                 codes_checked
);

    logic [31:0]        fwd_hash;
    logic [31:0]        rev_hash;
    logic [31:0]        rev_weight;
    logic               odd_index;
    logic               sign_ext;
    logic signed [31:0] expected_codes[$];

    initial begin
        fail_count    = 0;
        codes_pending = 0;
        codes_checked = 0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] code check: %s", $time, what);
        fail_count++;
    endtask

    // key from the id, then the three-way product; everything wraps at 32 bits
    function automatic logic [31:0] lyric_code(input logic [31:0] h1, input logic [31:0] h2,
                                               input logic [31:0] id);
        logic [31:0] key;
        key = {id[7:0],
               (id[23:16] == 8'd0) ? ~id[15:8] : id[23:16],
               id[15:8],
               (id[31:24] == 8'd0) ? ~id[7:0]  : id[31:24]};
        return ((h2 ^ key) + (h1 | id)) * (h1 | key) * (h2 ^ id);
    endfunction

    always @(posedge aclk) begin
        logic [31:0]        val;
        logic signed [31:0] want;
        if (!aresetn) begin
            fwd_hash   = '0;
            rev_hash   = '0;
            rev_weight = 32'd1;
            odd_index  = 1'b0;
            sign_ext   = 1'b1;
            expected_codes.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                sign_ext = cfg_byte_is_signed;

            // results first: one arriving on an empty store is unexpected
            if (m_valid && m_ready) begin
                if (expected_codes.size() == 0) begin
                    report_mismatch($sformatf("unexpected code %h", m_code));
                end else begin
                    want = expected_codes.pop_front();
                    codes_checked++;
                    if (m_code !== want)
                        report_mismatch($sformatf("code %h, expected %h", m_code, want));
                end
            end

            if (s_valid && s_ready) begin
                if (!s_no_byte) begin
                    val = sign_ext ? {{24{s_data_byte[7]}}, s_data_byte}
                                   : {24'd0, s_data_byte};
                    fwd_hash   = fwd_hash * (odd_index ? FWD_MULT_ODD : FWD_MULT_EVEN) + val;
                    rev_hash   = rev_hash + val * rev_weight;
                    rev_weight = rev_weight * (odd_index ? WGT_MULT_ODD : WGT_MULT_EVEN);
                    odd_index  = ~odd_index;
                end
                if (s_last_byte) begin
                    expected_codes.push_back(lyric_code(fwd_hash, rev_hash, s_song_id));
                    fwd_hash   = '0;
                    rev_hash   = '0;
                    rev_weight = 32'd1;
                    odd_index  = 1'b0;
                end
            end
        end
        codes_pending <= expected_codes.size();
    end

endmodule

/* bench/tb_lyric_id_string_code_core.sv */
// Testbench top for lyric_id_string_code_core: clock, reset, string and setting
// stimulus, receiver back-pressure and the verdict. Depends on the block itself
// and lisc_code_checker.
module tb_lyric_id_string_code_core;

    // pause after the store of expected codes empties before touching the setting:
    // lets a byte still in flight finish its hash and weight update
    localparam int SETTLE_CYCLES = 12;
    localparam int STRING_TARGET = 1400;

    // receiver back-pressure patterns
    typedef enum logic [1:0] {
        RX_FLOW,
        RX_RANDOM,
        RX_SPARSE,
        RX_HOLD
    } rx_mode_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_data_byte;
    logic               s_no_byte;
    logic               s_last_byte;
    logic [31:0]        s_song_id;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_code;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_byte_is_signed;

    int fail_count;
    int codes_pending;
    int codes_checked;

    // stimulus bookkeeping
    int       burst_left   = 0;
    int       items_sent   = 0;   // transactions that do something
    int       bytes_sent   = 0;
    int       strings_sent = 0;
    int       ignored_sent = 0;   // empty, non-last transactions
    int       setting_writes = 0;
    rx_mode_t rx_mode  = RX_FLOW;
    int       rx_hold  = 0;

    lyric_id_string_code_core dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_no_byte          (s_no_byte),
        .s_last_byte        (s_last_byte),
        .s_song_id          (s_song_id),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_code             (m_code),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_byte_is_signed (cfg_byte_is_signed)
    );

    lisc_code_checker u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_no_byte          (s_no_byte),
        .s_last_byte        (s_last_byte),
        .s_song_id          (s_song_id),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_code             (m_code),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_byte_is_signed (cfg_byte_is_signed),
        .fail_count         (fail_count),
        .codes_pending      (codes_pending),
        .codes_checked      (codes_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // hard stop: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: picks a pattern, keeps it for a while, then picks another.
    // RX_HOLD gives the long stalls that back up into the input side.
    always @(posedge aclk) begin
        if (rx_hold == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_hold <= $urandom_range(8, 64);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        case (rx_mode)
            RX_FLOW:   m_ready <= 1'b1;
            RX_RANDOM: m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= ($urandom_range(0, 7) == 0);
            default:   m_ready <= 1'b0;
        endcase
    end

    // One string transaction. The sender runs in bursts; between bursts valid
    // may drop for a random gap. Valid is never dropped and raised in one step.
    task automatic send_item(input logic [7:0] b, input logic nb, input logic lst,
                             input logic [31:0] id);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_no_byte   <= nb;
        s_last_byte <= lst;
        s_song_id   <= id;
        do @(posedge aclk); while (!s_ready);
        if (nb && !lst) begin
            ignored_sent++;
        end else begin
            items_sent++;
            if (!nb)
                bytes_sent++;
            if (lst)
                strings_sent++;
        end
    endtask

    // Stop sending and wait until every predicted code has been taken, then let
    // any trailing byte work finish so the block is idle.
    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);   // checker's pending count is registered, so it trails the accept
        while (codes_pending != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Setting write; caller has drained first.
    task automatic write_setting(input logic v);
        cfg_valid          <= 1'b1;
        cfg_byte_is_signed <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        setting_writes++;
    endtask

    // A string of len bytes with random content biased to the byte extremes,
    // sprinkled with ignored empty transactions. When terminated, the last mark
    // rides either on the final byte or on a trailing empty transaction.
    task automatic send_string(input int len, input logic terminate);
        logic [7:0]  b;
        logic [31:0] id;
        logic        last_on_byte;
        for (int j = 0; j < 4; j++) begin
            case ($urandom_range(0, 7))
                0, 1:    id[j*8 +: 8] = 8'h00;   // forces the inverted-byte key path for id bytes 2 and 3
                2:       id[j*8 +: 8] = 8'hFF;
                default: id[j*8 +: 8] = 8'($urandom);
            endcase
        end
        last_on_byte = terminate && (len > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_item(8'($urandom), 1'b1, 1'b0, $urandom);
            case ($urandom_range(0, 7))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                2:       b = 8'h80;
                3:       b = 8'h7F;
                default: b = 8'($urandom);
            endcase
            if (last_on_byte && i == len - 1)
                send_item(b, 1'b0, 1'b1, id);
            else
                send_item(b, 1'b0, 1'b0, $urandom);
        end
        if (terminate && !last_on_byte)
            send_item(8'($urandom), 1'b1, 1'b1, id);
    endtask

    initial begin
        int phase;
        int n_strings;
        int len;

        aresetn            <= 1'b0;
        s_valid            <= 1'b0;
        s_data_byte        <= 8'd0;
        s_no_byte          <= 1'b0;
        s_last_byte        <= 1'b0;
        s_song_id          <= 32'd0;
        cfg_valid          <= 1'b0;
        cfg_byte_is_signed <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed: sign extension on (reset value) ----
        send_item(8'h00, 1'b1, 1'b1, 32'h0000_0000);   // empty string, all-zero id
        send_item(8'hFF, 1'b0, 1'b1, 32'hFFFF_FFFF);   // one byte, all-ones id
        send_item(8'h80, 1'b0, 1'b1, 32'h0000_00FF);   // both replaced key bytes
        send_item(8'h7F, 1'b0, 1'b1, 32'h00FF_0000);   // top id byte zero, byte 2 not: one key byte replaced
        send_item(8'h00, 1'b0, 1'b1, 32'hFF00_FF00);   // id byte 2 zero, top byte not: one key byte replaced
        // short string with an ignored empty transaction inside, closed by an
        // empty last transaction
        send_item(8'h41, 1'b0, 1'b0, 32'h0000_0000);
        send_item(8'hA5, 1'b1, 1'b0, 32'hFFFF_FFFF);
        send_item(8'h81, 1'b0, 1'b0, 32'h0000_0000);
        send_item(8'h01, 1'b0, 1'b0, 32'h0000_0000);
        send_item(8'h00, 1'b1, 1'b1, 32'h1234_5678);

        // ---- directed: sign extension off ----
        drain();
        write_setting(1'b0);
        send_item(8'hFF, 1'b0, 1'b1, 32'hDEAD_BEEF);
        send_item(8'h80, 1'b0, 1'b0, 32'h0000_0000);
        send_item(8'hC3, 1'b0, 1'b1, 32'h0000_0001);
        send_item(8'h00, 1'b1, 1'b1, 32'h8000_0000);

        // setting changed part-way through a string: applies from the next byte
        send_item(8'hF0, 1'b0, 1'b0, 32'h0000_0000);
        drain();
        write_setting(1'b1);
        send_item(8'hF0, 1'b0, 1'b1, 32'h0101_0101);

        // ---- random phases ----
        // Each phase starts from a drained block with a fresh setting: on, off,
        // then a coin toss. Some phases stop mid-string so the next setting lands
        // part-way through it.
        phase = 0;
        while (items_sent < STRING_TARGET) begin
            drain();
            case (phase % 3)
                0:       write_setting(1'b1);
                1:       write_setting(1'b0);
                default: write_setting(1'($urandom_range(0, 1)));
            endcase
            n_strings = $urandom_range(3, 12);
            for (int s = 0; s < n_strings; s++) begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(0, 10);
                send_string(len, 1'b1);
            end
            if ($urandom_range(0, 4) == 0)
                send_string($urandom_range(1, 6), 1'b0);
            phase++;
        end
        send_string($urandom_range(0, 10), 1'b1);   // close any string left open
        drain();

        $display("covered %0d strings, %0d bytes, %0d ignored empties, %0d codes compared",
                 strings_sent, bytes_sent, ignored_sent, codes_checked);
        $display("sign extension written %0d times, some writes part-way through a string",
                 setting_writes);
        if (fail_count == 0 && codes_pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/lisc_pkg.sv
design/lisc_mac.sv
design/lisc_seq.sv
design/lyric_id_string_code_core.sv
bench/lisc_code_checker.sv
bench/tb_lyric_id_string_code_core.sv
